// ===== sv/dmb_pkg.sv =====
// Package: constants, types and helpers for the diagonal motion blur block.
`timescale 1ns / 1ps
package dmb_pkg;

    localparam int FRAME_WIDTH  = 64;
    localparam int FRAME_HEIGHT = 64;
    localparam int KERNEL_W     = 9;
    localparam int KERNEL_H     = 9;

    localparam int DIAG_TAPS   = (KERNEL_W < KERNEL_H) ? KERNEL_W : KERNEL_H;
    localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;

    localparam int COORD_W = 6;
    localparam int PIX_W   = 24;
    localparam int CHAN_W  = 8;
    localparam int COL_W   = $clog2(FRAME_WIDTH);
    localparam int ROW_W   = $clog2(FRAME_HEIGHT);
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int TAP_W   = (DIAG_TAPS > 1) ? $clog2(DIAG_TAPS) : 1;
    localparam int SUM_W   = $clog2(DIAG_TAPS * 255 + 1);

    // Offsets that move the query point to the first diagonal tap, kept in 0..size-1.
    localparam int OFF_X = (FRAME_WIDTH - (KERNEL_W / 2) % FRAME_WIDTH) % FRAME_WIDTH;
    localparam int OFF_Y = (FRAME_HEIGHT - (KERNEL_H / 2) % FRAME_HEIGHT) % FRAME_HEIGHT;

    // floor(sum / 9) == (sum * 7282) >> 16 for every sum below 8192.
    localparam int RECIP_W   = 13;
    localparam int RECIP9    = 7282;
    localparam int RECIP_SH  = 16;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int CHAN_MAX  = 255;

    localparam logic [0:0] OP_LOAD  = 1'b0;
    localparam logic [0:0] OP_QUERY = 1'b1;

    typedef struct packed {
        logic start;   // query transfer: set up taps, clear sums
        logic wr;      // load transfer: write the frame store
        logic rd;      // issue one tap read
        logic mul;     // register reciprocal products
        logic finish;  // load result register
    } dmb_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dmb_stat_t;

    function automatic logic [CHAN_W-1:0] dmb_clamp(input logic [PROD_W-1:0] prod);
        logic [PROD_W-RECIP_SH-1:0] q;
        q = prod[PROD_W-1:RECIP_SH];
        dmb_clamp = (q > (PROD_W-RECIP_SH)'(CHAN_MAX)) ? CHAN_W'(CHAN_MAX) : q[CHAN_W-1:0];
    endfunction

endpackage

// ===== sv/diagonal_motion_blur.sv =====
// Top level: diagonal motion blur over a stored RGB frame.
// Load: no result; the next item is taken in the following cycle.
// Query: one read per tap, then sum, multiply and result stages; no new item is taken
//   until the result register is loaded, which waits while a held result is stalled.
// The result register frees the input side while a result waits for transfer.
// Reset (rst_n, async, active low) clears control; frame store contents are undefined.
`timescale 1ns / 1ps
module diagonal_motion_blur (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [dmb_pkg::COORD_W-1:0]     x_coord,
    input  logic [dmb_pkg::COORD_W-1:0]     y_coord,
    input  logic [dmb_pkg::PIX_W-1:0]       pixel_in,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dmb_pkg::PIX_W-1:0]       blurred_pixel
);
    import dmb_pkg::*;

    dmb_cmd_t  cmd;
    dmb_stat_t stat;

    dmb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .stat     (stat),
        .cmd      (cmd)
    );

    dmb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .pixel_in      (pixel_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .blurred_pixel (blurred_pixel)
    );

endmodule

// ===== sv/dmb_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module dmb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/dmb_datapath.sv =====
// Datapath: frame store, tap address walk, channel sums, divide by 9, result register.
`timescale 1ns / 1ps
module dmb_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dmb_pkg::dmb_cmd_t                    cmd,
    output dmb_pkg::dmb_stat_t                   stat,
    input  logic [dmb_pkg::COORD_W-1:0]          x_coord,
    input  logic [dmb_pkg::COORD_W-1:0]          y_coord,
    input  logic [dmb_pkg::PIX_W-1:0]            pixel_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [dmb_pkg::PIX_W-1:0]            blurred_pixel
);
    import dmb_pkg::*;

    logic [COL_W-1:0]  x_mod;
    logic [ROW_W-1:0]  y_mod;
    logic [COL_W:0]    col_start;
    logic [ROW_W:0]    row_start;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ADDR_W-1:0] load_addr, tap_addr, ram_addr;
    logic [PIX_W-1:0]  ram_rdata;
    logic              pend_reg;
    logic [SUM_W-1:0]  acc_r_reg, acc_g_reg, acc_b_reg;
    logic [SUM_W-1:0]  acc_r_next, acc_g_next, acc_b_next;
    logic [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic              out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]  out_pix_reg;

    assign x_mod     = COL_W'(x_coord % FRAME_WIDTH);
    assign y_mod     = ROW_W'(y_coord % FRAME_HEIGHT);
    assign col_start = {1'b0, x_mod} + (COL_W+1)'(OFF_X);
    assign row_start = {1'b0, y_mod} + (ROW_W+1)'(OFF_Y);

    assign load_addr = ADDR_W'(y_mod * FRAME_WIDTH + x_mod);
    assign tap_addr  = ADDR_W'(row_reg * FRAME_WIDTH + col_reg);
    assign ram_addr  = cmd.wr ? load_addr : tap_addr;

    dmb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (cmd.wr),
        .re    (cmd.rd),
        .addr  (ram_addr),
        .wdata (pixel_in),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.start)
        begin
            col_next = (col_start >= (COL_W+1)'(FRAME_WIDTH)) ?
                       COL_W'(col_start - (COL_W+1)'(FRAME_WIDTH)) : col_start[COL_W-1:0];
            row_next = (row_start >= (ROW_W+1)'(FRAME_HEIGHT)) ?
                       ROW_W'(row_start - (ROW_W+1)'(FRAME_HEIGHT)) : row_start[ROW_W-1:0];
        end
        else if (cmd.rd)
        begin
            col_next = (col_reg == COL_W'(FRAME_WIDTH - 1)) ? '0 : col_reg + 1'b1;
            row_next = (row_reg == ROW_W'(FRAME_HEIGHT - 1)) ? '0 : row_reg + 1'b1;
        end
    end

    always_comb
    begin
        acc_r_next = acc_r_reg;
        acc_g_next = acc_g_reg;
        acc_b_next = acc_b_reg;
        if (cmd.start)
        begin
            acc_r_next = '0;
            acc_g_next = '0;
            acc_b_next = '0;
        end
        else if (pend_reg)
        begin
            acc_r_next = acc_r_reg + SUM_W'(ram_rdata[23:16]);
            acc_g_next = acc_g_reg + SUM_W'(ram_rdata[15:8]);
            acc_b_next = acc_b_reg + SUM_W'(ram_rdata[7:0]);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= cmd.rd;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg   <= col_next;
        row_reg   <= row_next;
        acc_r_reg <= acc_r_next;
        acc_g_reg <= acc_g_next;
        acc_b_reg <= acc_b_next;
        if (cmd.mul)
        begin
            prod_r_reg <= PROD_W'(acc_r_reg) * PROD_W'(RECIP9);
            prod_g_reg <= PROD_W'(acc_g_reg) * PROD_W'(RECIP9);
            prod_b_reg <= PROD_W'(acc_b_reg) * PROD_W'(RECIP9);
        end
        if (cmd.finish)
        begin
            out_pix_reg <= {dmb_clamp(prod_r_reg), dmb_clamp(prod_g_reg),
                            dmb_clamp(prod_b_reg)};
        end
    end

    assign stat.out_stall = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign blurred_pixel  = out_pix_reg;

endmodule

// ===== sv/dmb_ctrl.sv =====
// Controller: sequences loads, tap reads, sum, divide and result transfer.
`timescale 1ns / 1ps
module dmb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  dmb_pkg::dmb_stat_t stat,
    output dmb_pkg::dmb_cmd_t  cmd
);
    import dmb_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_ACC  = 5'b00100,
        S_MUL  = 5'b01000,
        S_DONE = 5'b10000
    } dmb_state_t;

    dmb_state_t       state_reg, state_next;
    logic [TAP_W-1:0] tap_reg, tap_next;
    logic             accept;
    logic             last_tap;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign last_tap = (tap_reg == TAP_W'(DIAG_TAPS - 1));

    always_comb
    begin
        state_next = state_reg;
        tap_next   = tap_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == OP_QUERY))
                begin
                    cmd.start  = 1'b1;
                    tap_next   = '0;
                    state_next = S_READ;
                end
                else if (accept)
                begin
                    cmd.wr = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.rd   = 1'b1;
                tap_next = tap_reg + 1'b1;
                if (last_tap)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

endmodule

// ===== sv/dmb_checker.sv =====
// Port-level checker for the diagonal motion blur block, with its bind.
`timescale 1ns / 1ps
module dmb_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        op,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [dmb_pkg::PIX_W-1:0]   blurred_pixel
);
    import dmb_pkg::*;

    // Held result keeps its value until transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blurred_pixel))
        else $error("result changed while stalled");

    // A query keeps the input side busy in the next cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_QUERY) |=> !in_ready)
        else $error("input taken while query in flight");

    // After a load the input side is open again in the next cycle.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (op == OP_LOAD) |=> in_ready)
        else $error("load did not complete in one cycle");

    // A new result never rises right after a sample in which input was open.
    a_result_late: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without query processing");

endmodule

bind diagonal_motion_blur dmb_checker u_dmb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .op            (op),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .blurred_pixel (blurred_pixel)
);

// ===== bench/diagonal_motion_blur_tb.sv =====
// Testbench: loads, blurred-pixel queries and backpressure on diagonal_motion_blur.
`timescale 1ns / 1ps
module diagonal_motion_blur_tb;
    import dmb_pkg::*;

    localparam int RAND_ITEMS  = 1050;
    localparam int CALM_FROM   = 900;
    localparam int HOLD_AT     = 300;
    localparam int PAUSE_AT    = 600;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BLUR_DIV    = 9;
    localparam int DIR_ROWS    = 18;

    typedef struct {
        logic [0:0]         kind;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pix;
        bit                 typed;
        logic [PIX_W-1:0]   want;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               op = OP_LOAD;
    logic [COORD_W-1:0] x_coord = '0;
    logic [COORD_W-1:0] y_coord = '0;
    logic [PIX_W-1:0]   pixel_in = '0;
    logic               out_ready = 1'b0;
    wire                in_ready;
    wire                out_valid;
    wire  [PIX_W-1:0]   blurred_pixel;

    logic [PIX_W-1:0]   frame_copy [STORE_DEPTH];
    bit                 loaded [STORE_DEPTH];
    logic [PIX_W-1:0]   blur_queue [$];
    int                 errors = 0;
    int                 cycle_count = 0;
    int                 rand_count = 0;
    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;

    // Main diagonal around (0,0) loaded white, then corner and wrap queries.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{OP_LOAD,  6'd60, 6'd60, 24'hFFFFFF, 1'b0, 24'h000000},
        '{OP_LOAD,  6'd61, 6'd61, 24'hFFFFFF, 1'b0, 24'h000000},
        '{OP_LOAD,  6'd62, 6'd62, 24'hFFFFFF, 1'b0, 24'h000000},
        '{OP_LOAD,  6'd63, 6'd63, 24'hFFFFFF, 1'b0, 24'h000000},
        '{OP_LOAD,  6'd0,  6'd0,  24'hFFFFFF, 1'b0, 24'h000000},
        '{OP_LOAD,  6'd1,  6'd1,  24'hFFFFFF, 1'b0, 24'h000000},
        '{OP_LOAD,  6'd2,  6'd2,  24'hFFFFFF, 1'b0, 24'h000000},
        '{OP_LOAD,  6'd3,  6'd3,  24'hFFFFFF, 1'b0, 24'h000000},
        '{OP_LOAD,  6'd4,  6'd4,  24'hFFFFFF, 1'b0, 24'h000000},
        '{OP_QUERY, 6'd0,  6'd0,  24'h000000, 1'b1, 24'hFFFFFF},
        '{OP_LOAD,  6'd0,  6'd0,  24'h000000, 1'b0, 24'h000000},
        '{OP_QUERY, 6'd0,  6'd0,  24'hFFFFFF, 1'b1, 24'hE2E2E2},
        '{OP_LOAD,  6'd63, 6'd63, 24'hFF0000, 1'b0, 24'h000000},
        '{OP_QUERY, 6'd0,  6'd0,  24'h000000, 1'b0, 24'h000000},
        '{OP_LOAD,  6'd59, 6'd59, 24'hA5A5A5, 1'b0, 24'h000000},
        '{OP_QUERY, 6'd63, 6'd63, 24'hFFFFFF, 1'b0, 24'h000000},
        '{OP_LOAD,  6'd5,  6'd5,  24'h5A5A5A, 1'b0, 24'h000000},
        '{OP_QUERY, 6'd1,  6'd1,  24'h000000, 1'b0, 24'h000000}
    };

    diagonal_motion_blur dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .pixel_in      (pixel_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .blurred_pixel (blurred_pixel)
    );

    always #1 clk = ~clk;

    function automatic int wrap_pos(input int pos, input int off, input int size);
        return (((pos + off) % size) + size) % size;
    endfunction

    function automatic int tap_index(input int cx, input int cy, input int t);
        int tx;
        int ty;
        tx = wrap_pos(cx % FRAME_WIDTH, t - KERNEL_W / 2, FRAME_WIDTH);
        ty = wrap_pos(cy % FRAME_HEIGHT, t - KERNEL_H / 2, FRAME_HEIGHT);
        return ty * FRAME_WIDTH + tx;
    endfunction

    function automatic logic [CHAN_W-1:0] scale_channel(input int sum);
        int q;
        q = sum / BLUR_DIV;
        return (q > 255) ? 8'hFF : q[CHAN_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] blur_at(input int cx, input int cy);
        int               r;
        int               g;
        int               b;
        logic [PIX_W-1:0] v;
        r = 0;
        g = 0;
        b = 0;
        for (int t = 0; t < DIAG_TAPS; t++)
        begin
            v = frame_copy[tap_index(cx, cy, t)];
            r += v[23:16];
            g += v[15:8];
            b += v[7:0];
        end
        return {scale_channel(r), scale_channel(g), scale_channel(b)};
    endfunction

    function automatic bit taps_loaded(input int cx, input int cy);
        for (int t = 0; t < DIAG_TAPS; t++)
        begin
            if (!loaded[tap_index(cx, cy, t)])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        logic [PIX_W-1:0] p;
        for (int c = 0; c < 3; c++)
        begin
            case ($urandom_range(0, 3))
                0: p[c*8 +: 8] = 8'h00;
                1: p[c*8 +: 8] = 8'hFF;
                default: p[c*8 +: 8] = 8'($urandom);
            endcase
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] want);
        $display("error: %s got %06h want %06h at cycle %0d", what, got, want, cycle_count);
        errors++;
    endtask

    task automatic rest(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0)
            rest($urandom_range(1, 10));
    endtask

    // Drive one item, wait for its transfer, then update the shadow frame or queue the expected result.
    task automatic push_item(input logic [0:0] kind, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [PIX_W-1:0] pix,
                             input bit typed, input logic [PIX_W-1:0] want);
        int idx;
        in_valid <= 1'b1;
        op       <= kind;
        x_coord  <= cx;
        y_coord  <= cy;
        pixel_in <= pix;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        idx = (int'(cy) % FRAME_HEIGHT) * FRAME_WIDTH + (int'(cx) % FRAME_WIDTH);
        if (kind == OP_LOAD)
        begin
            frame_copy[idx] = pix;
            loaded[idx] = 1'b1;
        end
        else
            blur_queue.push_back(typed ? want : blur_at(cx, cy));
    endtask

    task automatic random_item(input logic [0:0] kind, input int cx, input int cy);
        maybe_gap();
        push_item(kind, COORD_W'(cx), COORD_W'(cy),
                  (kind == OP_LOAD) ? pick_pixel() : PIX_W'($urandom), 1'b0, '0);
        rand_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (blur_queue.size() == 0)
                report_mismatch("unexpected result", blurred_pixel, '0);
            else if (blurred_pixel !== blur_queue[0])
                report_mismatch("blurred_pixel", blurred_pixel, blur_queue.pop_front());
            else
                void'(blur_queue.pop_front());
        end
    end

    // Receiver: random ready bursts, one long hold on request, steady ready when calm.
    initial
    begin
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !calm)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int  r;
        int  qx;
        int  qy;
        int  idx;
        bit  found;
        bit  hold_done;
        bit  pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            maybe_gap();
            push_item(dir_rows[i].kind, dir_rows[i].col, dir_rows[i].row,
                      dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].want);
        end

        while (rand_count < RAND_ITEMS)
        begin
            calm = (rand_count >= CALM_FROM);
            if (!hold_done && rand_count >= HOLD_AT)
            begin
                hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && rand_count >= PAUSE_AT)
            begin
                rest(1);
                while (blur_queue.size() != 0)
                    @(posedge clk);
                pause_done = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                // load the missing taps of a random point, then query it
                qx = $urandom_range(0, FRAME_WIDTH - 1);
                qy = $urandom_range(0, FRAME_HEIGHT - 1);
                for (int t = 0; t < DIAG_TAPS; t++)
                begin
                    idx = tap_index(qx, qy, t);
                    if (!loaded[idx])
                        random_item(OP_LOAD, idx % FRAME_WIDTH, idx / FRAME_WIDTH);
                end
                random_item(OP_QUERY, qx, qy);
            end
            else if (r < 80)
            begin
                found = 1'b0;
                for (int k = 0; k < 8 && !found; k++)
                begin
                    qx = $urandom_range(0, FRAME_WIDTH - 1);
                    qy = $urandom_range(0, FRAME_HEIGHT - 1);
                    found = taps_loaded(qx, qy);
                end
                if (found)
                    random_item(OP_QUERY, qx, qy);
            end
            else
                random_item(OP_LOAD, $urandom_range(0, FRAME_WIDTH - 1),
                            $urandom_range(0, FRAME_HEIGHT - 1));
        end

        calm = 1'b1;
        in_valid <= 1'b0;
        while (blur_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
